/* src/tps_pkg.sv */
package tps_pkg;

   localparam int IN_SLOTS = 5;
   localparam int CORNERS = 4;

   localparam int PRESSURE_GAIN = 1765;
   localparam int PRESSURE_BIAS = 13643;
   localparam int PRESSURE_OFFSET = 1024;
   localparam int TEMP_OFFSET = 40;

   localparam logic [1:0] CMD_CORNER_MAP = 2'd0;
   localparam logic [1:0] CMD_PRESSURE = 2'd1;
   localparam logic [1:0] CMD_TEMP = 2'd2;
   localparam logic [1:0] CMD_UNSUPPORTED = 2'd3;

   localparam logic [1:0] STATUS_APPLIED = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_NO_MAP = 2'd2;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

   localparam logic [1:0] ALERT_NORMAL = 2'd0;
   localparam logic [1:0] ALERT_WARN = 2'd1;
   localparam logic [1:0] ALERT_ALERT = 2'd2;

   localparam logic [1:0] CSR_PRESSURE_WARN = 2'd0;
   localparam logic [1:0] CSR_PRESSURE_ALERT = 2'd1;
   localparam logic [1:0] CSR_TEMP_WARN = 2'd2;
   localparam logic [1:0] CSR_TEMP_ALERT = 2'd3;

   localparam logic [12:0] PRESSURE_WARN_RESET = 13'd3840;
   localparam logic [12:0] PRESSURE_ALERT_RESET = 13'd3520;
   localparam logic [8:0] TEMP_WARN_RESET = 9'd90;
   localparam logic [8:0] TEMP_ALERT_RESET = 9'd100;

   typedef logic [2:0] corner_type;
   typedef logic signed [13:0] pressure_type;
   typedef logic signed [8:0] temp_type;
   typedef logic [1:0] alert_type;

   typedef struct packed {
      corner_type corner;
      logic nonzero;
      pressure_type pressure;
      temp_type temp;
   } lane_type;

   typedef struct packed {
      logic [12:0] pressure_warn;
      logic [12:0] pressure_alert;
      temp_type temp_warn;
      temp_type temp_alert;
   } thresh_type;

endpackage

/* src/tps_lane.sv */
module tps_lane (
   input logic clock,
   input logic load,
   input logic [7:0] slot_byte,
   output tps_pkg::lane_type lane_ff
);

   logic [18:0] scaled;
   tps_pkg::lane_type lane_in;

   assign scaled = 19'(slot_byte) * 19'(tps_pkg::PRESSURE_GAIN) + 19'(tps_pkg::PRESSURE_BIAS);

   always_comb begin
      lane_in.corner = (slot_byte >= 8'd1 && slot_byte <= 8'd4) ? slot_byte[2:0] : '0;
      lane_in.nonzero = (slot_byte != 8'd0);
      lane_in.pressure = tps_pkg::pressure_type'({1'b0, scaled[18:6]})
                       - tps_pkg::pressure_type'(tps_pkg::PRESSURE_OFFSET);
      lane_in.temp = tps_pkg::temp_type'({1'b0, slot_byte})
                   - tps_pkg::temp_type'(tps_pkg::TEMP_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

/* src/tps_merge.sv */
module tps_merge #(
   parameter int SLOT_COUNT = 5
) (
   input tps_pkg::lane_type lanes[SLOT_COUNT],
   input tps_pkg::corner_type slot_corner[SLOT_COUNT],
   input logic use_pressure,
   input tps_pkg::pressure_type pressure_old[tps_pkg::CORNERS],
   input tps_pkg::temp_type temp_old[tps_pkg::CORNERS],
   input tps_pkg::thresh_type thresh,
   output tps_pkg::pressure_type pressure_new[tps_pkg::CORNERS],
   output tps_pkg::temp_type temp_new[tps_pkg::CORNERS],
   output tps_pkg::alert_type alert_new[tps_pkg::CORNERS]
);

   tps_pkg::pressure_type pick_pressure[tps_pkg::CORNERS];
   tps_pkg::temp_type pick_temp[tps_pkg::CORNERS];

   // Later slots override earlier ones on the same corner.
   always_comb begin
      for (int k = 0; k < tps_pkg::CORNERS; k++) begin
         pick_pressure[k] = '0;
         pick_temp[k] = '0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (lanes[s].nonzero && slot_corner[s] == tps_pkg::corner_type'(k + 1)) begin
               pick_pressure[k] = lanes[s].pressure;
               pick_temp[k] = lanes[s].temp;
            end
         end
         pressure_new[k] = use_pressure ? pick_pressure[k] : pressure_old[k];
         temp_new[k] = use_pressure ? temp_old[k] : pick_temp[k];
      end
   end

   always_comb begin
      for (int k = 0; k < tps_pkg::CORNERS; k++) begin
         priority if (pressure_new[k] <= 14'sd0) begin
            alert_new[k] = tps_pkg::ALERT_NORMAL;
         end else if (pressure_new[k] <= tps_pkg::pressure_type'({1'b0, thresh.pressure_alert})
                      || (temp_new[k] > 9'sd0 && temp_new[k] >= thresh.temp_alert)) begin
            alert_new[k] = tps_pkg::ALERT_ALERT;
         end else if (pressure_new[k] <= tps_pkg::pressure_type'({1'b0, thresh.pressure_warn})
                      || (temp_new[k] > 9'sd0 && temp_new[k] >= thresh.temp_warn)) begin
            alert_new[k] = tps_pkg::ALERT_WARN;
         end else begin
            alert_new[k] = tps_pkg::ALERT_NORMAL;
         end
      end
   end

endmodule

/* src/tyre_pressure_slot_decoder.sv */
// Channel   Direction  Handshake            Carries
// req_*     in         req_valid/req_stall  command, byte count, five slot bytes
// rsp_*     out        rsp_valid/rsp_stall  status, four pressures, four temps, alerts
// csr_*     in         csr_we               threshold register index and data
//
// One item is taken every cycle while req_stall is low; the result is valid once loaded.
// The slot lanes convert bytes in the first stage, and the merge stage updates the
// corner state and loads the result in the second.
// Reset clears the corner state and the result, and loads the threshold defaults.
// When the result is stalled and the first stage is full, req_stall rises in the
// same cycle.
module tyre_pressure_slot_decoder #(
   parameter int SLOT_COUNT = 5
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_command,
   input logic [7:0] req_byte_count,
   input logic [7:0] req_slot0_byte,
   input logic [7:0] req_slot1_byte,
   input logic [7:0] req_slot2_byte,
   input logic [7:0] req_slot3_byte,
   input logic [7:0] req_slot4_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic signed [13:0] rsp_pressure_front_left,
   output logic signed [13:0] rsp_pressure_front_right,
   output logic signed [13:0] rsp_pressure_rear_left,
   output logic signed [13:0] rsp_pressure_rear_right,
   output logic signed [8:0] rsp_temp_front_left,
   output logic signed [8:0] rsp_temp_front_right,
   output logic signed [8:0] rsp_temp_rear_left,
   output logic signed [8:0] rsp_temp_rear_right,
   output logic [7:0] rsp_alert_levels,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [12:0] csr_wdata
);

   logic [7:0] in_bytes[tps_pkg::IN_SLOTS];
   logic [7:0] slot_bytes[SLOT_COUNT];
   tps_pkg::lane_type lanes[SLOT_COUNT];

   logic accept;
   logic s2_fire;
   logic s1_valid_ff, s1_valid_in;
   logic [1:0] s1_command_ff;
   logic s1_short_ff, s1_short_in;
   logic [7:0] need_bytes;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic map_we, values_we, map_valid;

   tps_pkg::corner_type slot_corner_ff[SLOT_COUNT];
   tps_pkg::pressure_type pressure_ff[tps_pkg::CORNERS];
   tps_pkg::temp_type temp_ff[tps_pkg::CORNERS];
   tps_pkg::alert_type alert_ff[tps_pkg::CORNERS];
   tps_pkg::pressure_type pressure_new[tps_pkg::CORNERS];
   tps_pkg::temp_type temp_new[tps_pkg::CORNERS];
   tps_pkg::alert_type alert_new[tps_pkg::CORNERS];
   tps_pkg::thresh_type thresh_ff;

   assign in_bytes[0] = req_slot0_byte;
   assign in_bytes[1] = req_slot1_byte;
   assign in_bytes[2] = req_slot2_byte;
   assign in_bytes[3] = req_slot3_byte;
   assign in_bytes[4] = req_slot4_byte;

   assign accept = req_valid && !req_stall;
   assign s2_fire = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s2_fire;
   assign s1_valid_in = accept || (s1_valid_ff && !s2_fire);
   assign rsp_valid_in = s2_fire || (rsp_valid_ff && rsp_stall);

   assign need_bytes = (req_command == tps_pkg::CMD_PRESSURE) ? 8'(2 * SLOT_COUNT)
                                                               : 8'(SLOT_COUNT);
   assign s1_short_in = (req_byte_count < need_bytes);

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_lane
      if (s < tps_pkg::IN_SLOTS) begin : g_byte
         assign slot_bytes[s] = in_bytes[s];
      end else begin : g_zero
         assign slot_bytes[s] = '0;
      end
      tps_lane u_lane (
         .clock(clock),
         .load(accept),
         .slot_byte(slot_bytes[s]),
         .lane_ff(lanes[s])
      );
   end

   tps_merge #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_merge (
      .lanes(lanes),
      .slot_corner(slot_corner_ff),
      .use_pressure(s1_command_ff == tps_pkg::CMD_PRESSURE),
      .pressure_old(pressure_ff),
      .temp_old(temp_ff),
      .thresh(thresh_ff),
      .pressure_new(pressure_new),
      .temp_new(temp_new),
      .alert_new(alert_new)
   );

   always_comb begin
      map_valid = 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (slot_corner_ff[s] != '0) begin
            map_valid = 1'b1;
         end
      end
   end

   always_comb begin
      status_in = tps_pkg::STATUS_APPLIED;
      map_we = 1'b0;
      values_we = 1'b0;
      unique case (s1_command_ff)
         tps_pkg::CMD_CORNER_MAP: begin
            if (s1_short_ff) begin
               status_in = tps_pkg::STATUS_SHORT;
            end else begin
               map_we = 1'b1;
            end
         end
         tps_pkg::CMD_PRESSURE, tps_pkg::CMD_TEMP: begin
            priority if (s1_short_ff) begin
               status_in = tps_pkg::STATUS_SHORT;
            end else if (!map_valid) begin
               status_in = tps_pkg::STATUS_NO_MAP;
            end else begin
               values_we = 1'b1;
            end
         end
         tps_pkg::CMD_UNSUPPORTED: begin
            status_in = tps_pkg::STATUS_UNSUPPORTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_command_ff <= req_command;
         s1_short_ff <= s1_short_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff <= tps_pkg::STATUS_APPLIED;
         thresh_ff.pressure_warn <= tps_pkg::PRESSURE_WARN_RESET;
         thresh_ff.pressure_alert <= tps_pkg::PRESSURE_ALERT_RESET;
         thresh_ff.temp_warn <= tps_pkg::TEMP_WARN_RESET;
         thresh_ff.temp_alert <= tps_pkg::TEMP_ALERT_RESET;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_corner_ff[s] <= '0;
         end
         for (int k = 0; k < tps_pkg::CORNERS; k++) begin
            pressure_ff[k] <= '0;
            temp_ff[k] <= '0;
            alert_ff[k] <= tps_pkg::ALERT_NORMAL;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_fire) begin
            status_ff <= status_in;
            if (map_we) begin
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  slot_corner_ff[s] <= lanes[s].corner;
               end
            end
            if (values_we) begin
               for (int k = 0; k < tps_pkg::CORNERS; k++) begin
                  pressure_ff[k] <= pressure_new[k];
                  temp_ff[k] <= temp_new[k];
                  alert_ff[k] <= alert_new[k];
               end
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               tps_pkg::CSR_PRESSURE_WARN: thresh_ff.pressure_warn <= csr_wdata;
               tps_pkg::CSR_PRESSURE_ALERT: thresh_ff.pressure_alert <= csr_wdata;
               tps_pkg::CSR_TEMP_WARN: thresh_ff.temp_warn <= csr_wdata[8:0];
               tps_pkg::CSR_TEMP_ALERT: thresh_ff.temp_alert <= csr_wdata[8:0];
            endcase
         end
      end
   end

   // The stored state only moves when a result is loaded, so it is the result payload.
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_pressure_front_left = pressure_ff[0];
   assign rsp_pressure_front_right = pressure_ff[1];
   assign rsp_pressure_rear_left = pressure_ff[2];
   assign rsp_pressure_rear_right = pressure_ff[3];
   assign rsp_temp_front_left = temp_ff[0];
   assign rsp_temp_front_right = temp_ff[1];
   assign rsp_temp_rear_left = temp_ff[2];
   assign rsp_temp_rear_right = temp_ff[3];
   assign rsp_alert_levels = {alert_ff[3], alert_ff[2], alert_ff[1], alert_ff[0]};

endmodule

/* src/tps_checker.sv */
module tps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [1:0] rsp_status,
   input logic signed [13:0] rsp_pressure_front_left,
   input logic [7:0] rsp_alert_levels
);

   // A result that is held back stays valid with the same status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("Stalled result changed or dropped.");

   // With a transfer in the first stage and the result held, the input must stall.
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(req_valid && !req_stall) && rsp_valid && rsp_stall |-> req_stall)
      else $error("Input accepted while both stages are full.");

   // A front left corner without a positive pressure reads as normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_front_left <= 14'sd0
      |-> rsp_alert_levels[1:0] == tps_pkg::ALERT_NORMAL)
      else $error("Alert raised on a corner without pressure.");

   // No corner carries the unused alert code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alert_levels[1:0] != 2'b11 && rsp_alert_levels[3:2] != 2'b11
                    && rsp_alert_levels[5:4] != 2'b11 && rsp_alert_levels[7:6] != 2'b11)
      else $error("Alert level code out of range.");

endmodule

bind tyre_pressure_slot_decoder tps_checker u_tps_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_status(rsp_status),
   .rsp_pressure_front_left(rsp_pressure_front_left),
   .rsp_alert_levels(rsp_alert_levels)
);

/* tb/tb_tyre_pressure_slot_decoder.sv */
`timescale 1ns / 1ps

module tb_tyre_pressure_slot_decoder;

   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 90;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] byte_count;
      logic [tps_pkg::IN_SLOTS-1:0][7:0] slot;
   } message_type;

   typedef struct packed {
      logic [1:0] status;
      logic [tps_pkg::CORNERS-1:0][13:0] pressure;
      logic [tps_pkg::CORNERS-1:0][8:0] temp;
      logic [7:0] alerts;
   } snapshot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic [7:0] req_byte_count = '0;
   logic [7:0] req_slot0_byte = '0;
   logic [7:0] req_slot1_byte = '0;
   logic [7:0] req_slot2_byte = '0;
   logic [7:0] req_slot3_byte = '0;
   logic [7:0] req_slot4_byte = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [13:0] rsp_pressure_front_left;
   logic signed [13:0] rsp_pressure_front_right;
   logic signed [13:0] rsp_pressure_rear_left;
   logic signed [13:0] rsp_pressure_rear_right;
   logic signed [8:0] rsp_temp_front_left;
   logic signed [8:0] rsp_temp_front_right;
   logic signed [8:0] rsp_temp_rear_left;
   logic signed [8:0] rsp_temp_rear_right;
   logic [7:0] rsp_alert_levels;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [12:0] csr_wdata = '0;

   message_type pending_messages [$];
   snapshot_type expected_snapshots [$];

   tps_pkg::corner_type mapped_corner [tps_pkg::IN_SLOTS] = '{default: '0};
   int corner_kpa [tps_pkg::CORNERS] = '{default: 0};
   int corner_degc [tps_pkg::CORNERS] = '{default: 0};
   tps_pkg::alert_type corner_level [tps_pkg::CORNERS] = '{default: '0};
   logic [12:0] warn_kpa_limit = tps_pkg::PRESSURE_WARN_RESET;
   logic [12:0] alert_kpa_limit = tps_pkg::PRESSURE_ALERT_RESET;
   int warn_degc_limit = int'($signed(tps_pkg::TEMP_WARN_RESET));
   int alert_degc_limit = int'($signed(tps_pkg::TEMP_ALERT_RESET));

   string corner_label [tps_pkg::CORNERS] =
      '{"front left", "front right", "rear left", "rear right"};

   message_type held_message;
   int send_gap = 0;
   bit send_burst = 1'b0;
   int stall_left = 0;
   bit recv_burst = 1'b0;
   int mismatches = 0;
   int quiet_cycles = 0;

   tyre_pressure_slot_decoder u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_byte_count(req_byte_count),
      .req_slot0_byte(req_slot0_byte),
      .req_slot1_byte(req_slot1_byte),
      .req_slot2_byte(req_slot2_byte),
      .req_slot3_byte(req_slot3_byte),
      .req_slot4_byte(req_slot4_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_pressure_front_left(rsp_pressure_front_left),
      .rsp_pressure_front_right(rsp_pressure_front_right),
      .rsp_pressure_rear_left(rsp_pressure_rear_left),
      .rsp_pressure_rear_right(rsp_pressure_rear_right),
      .rsp_temp_front_left(rsp_temp_front_left),
      .rsp_temp_front_right(rsp_temp_front_right),
      .rsp_temp_rear_left(rsp_temp_rear_left),
      .rsp_temp_rear_right(rsp_temp_rear_right),
      .rsp_alert_levels(rsp_alert_levels),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic snapshot_type next_tyre_snapshot(message_type m);
      snapshot_type r;
      int fresh [tps_pkg::CORNERS];
      int need;
      int c;
      bit mapped;
      r = '0;
      r.status = tps_pkg::STATUS_APPLIED;
      need = (m.command == tps_pkg::CMD_PRESSURE) ? 2 * tps_pkg::IN_SLOTS : tps_pkg::IN_SLOTS;
      mapped = 1'b0;
      for (int s = 0; s < tps_pkg::IN_SLOTS; s++) begin
         if (mapped_corner[s] != 0) begin
            mapped = 1'b1;
         end
      end
      if (m.command == tps_pkg::CMD_UNSUPPORTED) begin
         r.status = tps_pkg::STATUS_UNSUPPORTED;
      end else if (m.byte_count < need) begin
         r.status = tps_pkg::STATUS_SHORT;
      end else if (m.command == tps_pkg::CMD_CORNER_MAP) begin
         for (int s = 0; s < tps_pkg::IN_SLOTS; s++) begin
            mapped_corner[s] = (m.slot[s] >= 1 && m.slot[s] <= 4) ? m.slot[s][2:0] : 3'd0;
         end
      end else if (!mapped) begin
         r.status = tps_pkg::STATUS_NO_MAP;
      end else begin
         for (int i = 0; i < tps_pkg::CORNERS; i++) begin
            fresh[i] = 0;
         end
         for (int s = 0; s < tps_pkg::IN_SLOTS; s++) begin
            c = mapped_corner[s];
            if (c != 0 && m.slot[s] != 0) begin
               if (m.command == tps_pkg::CMD_PRESSURE) begin
                  fresh[c - 1] = (int'(m.slot[s]) * 1765 - 51893) >>> 6;
               end else begin
                  fresh[c - 1] = int'(m.slot[s]) - 40;
               end
            end
         end
         for (int i = 0; i < tps_pkg::CORNERS; i++) begin
            if (m.command == tps_pkg::CMD_PRESSURE) begin
               corner_kpa[i] = fresh[i];
            end else begin
               corner_degc[i] = fresh[i];
            end
            if (corner_kpa[i] <= 0) begin
               corner_level[i] = tps_pkg::ALERT_NORMAL;
            end else if (corner_kpa[i] <= int'(alert_kpa_limit) ||
                         (corner_degc[i] > 0 && corner_degc[i] >= alert_degc_limit)) begin
               corner_level[i] = tps_pkg::ALERT_ALERT;
            end else if (corner_kpa[i] <= int'(warn_kpa_limit) ||
                         (corner_degc[i] > 0 && corner_degc[i] >= warn_degc_limit)) begin
               corner_level[i] = tps_pkg::ALERT_WARN;
            end else begin
               corner_level[i] = tps_pkg::ALERT_NORMAL;
            end
         end
      end
      for (int i = 0; i < tps_pkg::CORNERS; i++) begin
         r.pressure[i] = 14'(corner_kpa[i]);
         r.temp[i] = 9'(corner_degc[i]);
         r.alerts[2 * i +: 2] = corner_level[i];
      end
      return r;
   endfunction

   task automatic queue_message(logic [1:0] command, logic [7:0] count, logic [7:0] b0,
                                logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
      message_type m;
      m.command = command;
      m.byte_count = count;
      m.slot = {b4, b3, b2, b1, b0};
      pending_messages.push_back(m);
   endtask

   function automatic message_type random_message();
      message_type m;
      int pick;
      bit scrambled;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         m.command = tps_pkg::CMD_CORNER_MAP;
      end else if (pick < 55) begin
         m.command = tps_pkg::CMD_PRESSURE;
      end else if (pick < 92) begin
         m.command = tps_pkg::CMD_TEMP;
      end else begin
         m.command = tps_pkg::CMD_UNSUPPORTED;
      end
      if ($urandom_range(0, 9) == 0) begin
         m.byte_count = 8'($urandom_range(0, 2 * tps_pkg::IN_SLOTS - 1));
      end else if (m.command == tps_pkg::CMD_PRESSURE) begin
         m.byte_count = 8'($urandom_range(2 * tps_pkg::IN_SLOTS, 255));
      end else begin
         m.byte_count = 8'($urandom_range(tps_pkg::IN_SLOTS, 255));
      end
      scrambled = ($urandom_range(0, 11) == 0);
      for (int s = 0; s < tps_pkg::IN_SLOTS; s++) begin
         if (m.command == tps_pkg::CMD_CORNER_MAP) begin
            if (scrambled || $urandom_range(0, 4) == 0) begin
               m.slot[s] = 8'($urandom);
            end else begin
               m.slot[s] = 8'($urandom_range(1, 4));
            end
         end else if ($urandom_range(0, 7) == 0) begin
            m.slot[s] = 8'd0;
         end else begin
            m.slot[s] = 8'($urandom_range(1, 255));
         end
      end
      return m;
   endfunction

   task automatic queue_random_messages(int count);
      @(negedge clock);
      repeat (count) pending_messages.push_back(random_message());
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_messages.size() != 0 || req_valid || expected_snapshots.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [1:0] index, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         tps_pkg::CSR_PRESSURE_WARN: warn_kpa_limit = value;
         tps_pkg::CSR_PRESSURE_ALERT: alert_kpa_limit = value;
         tps_pkg::CSR_TEMP_WARN: warn_degc_limit = int'($signed(value[8:0]));
         tps_pkg::CSR_TEMP_ALERT: alert_degc_limit = int'($signed(value[8:0]));
         default: ;
      endcase
      @(posedge clock);
   endtask

   // The temperature registers hold nine bits, so the upper data bits are random.
   task automatic program_thresholds(int kpa_warn, int kpa_alert, int degc_warn, int degc_alert);
      write_threshold(tps_pkg::CSR_PRESSURE_WARN, 13'(kpa_warn));
      write_threshold(tps_pkg::CSR_PRESSURE_ALERT, 13'(kpa_alert));
      write_threshold(tps_pkg::CSR_TEMP_WARN, {4'($urandom), 9'(degc_warn)});
      write_threshold(tps_pkg::CSR_TEMP_ALERT, {4'($urandom), 9'(degc_alert)});
      csr_we <= 1'b0;
   endtask

   task automatic note_mismatch(string what, int want, int got);
      if (mismatches < 10) begin
         $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      end
      mismatches++;
   endtask

   task automatic check_snapshot();
      snapshot_type want;
      snapshot_type got;
      got.status = rsp_status;
      got.pressure[0] = rsp_pressure_front_left;
      got.pressure[1] = rsp_pressure_front_right;
      got.pressure[2] = rsp_pressure_rear_left;
      got.pressure[3] = rsp_pressure_rear_right;
      got.temp[0] = rsp_temp_front_left;
      got.temp[1] = rsp_temp_front_right;
      got.temp[2] = rsp_temp_rear_left;
      got.temp[3] = rsp_temp_rear_right;
      got.alerts = rsp_alert_levels;
      if (expected_snapshots.size() == 0) begin
         if (mismatches < 10) begin
            $display("%0t result transfer with no expected result pending", $time);
         end
         mismatches++;
      end else begin
         want = expected_snapshots.pop_front();
         if (got.status !== want.status) begin
            note_mismatch("status", want.status, got.status);
         end
         for (int i = 0; i < tps_pkg::CORNERS; i++) begin
            if (got.pressure[i] !== want.pressure[i]) begin
               note_mismatch($sformatf("pressure %s", corner_label[i]),
                             $signed(want.pressure[i]), $signed(got.pressure[i]));
            end
            if (got.temp[i] !== want.temp[i]) begin
               note_mismatch($sformatf("temperature %s", corner_label[i]),
                             $signed(want.temp[i]), $signed(got.temp[i]));
            end
         end
         if (got.alerts !== want.alerts) begin
            note_mismatch("alert levels", want.alerts, got.alerts);
         end
      end
   endtask

   // The expected result is worked out at the request transfer, in order of arrival.
   always @(posedge clock) begin
      bit load;
      load = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(0, 19);
      end else begin
         if (req_valid && !req_stall) begin
            expected_snapshots.push_back(next_tyre_snapshot(held_message));
            if ($urandom_range(0, 29) == 0) begin
               send_burst = !send_burst;
            end
            send_gap = send_burst ? 0 : $urandom_range(0, 19);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_messages.size() != 0) begin
               load = 1'b1;
            end
         end
         if (load) begin
            held_message = pending_messages.pop_front();
            req_valid <= 1'b1;
            req_command <= held_message.command;
            req_byte_count <= held_message.byte_count;
            req_slot0_byte <= held_message.slot[0];
            req_slot1_byte <= held_message.slot[1];
            req_slot2_byte <= held_message.slot[2];
            req_slot3_byte <= held_message.slot[3];
            req_slot4_byte <= held_message.slot[4];
         end else if (req_valid && !req_stall) begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_snapshot();
            if ($urandom_range(0, 29) == 0) begin
               recv_burst = !recv_burst;
            end
            stall_left = recv_burst ? 0 : $urandom_range(0, 19);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100);
      queue_message(tps_pkg::CMD_TEMP, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_message(tps_pkg::CMD_UNSUPPORTED, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd4, 8'd1, 8'd2, 8'd3, 8'd4, 8'd1);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd1);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd5, 8'd0, 8'd5, 8'd7, 8'd8, 8'd255);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd9, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd1, 8'd255, 8'd29, 8'd30, 8'd77);
      queue_message(tps_pkg::CMD_TEMP, 8'd4, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100);
      queue_message(tps_pkg::CMD_TEMP, 8'd5, 8'd255, 8'd1, 8'd40, 8'd139, 8'd9);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd255, 8'd0, 8'd170, 8'd168, 8'd0, 8'd50);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd255, 8'd2, 8'd2, 8'd4, 8'd9, 8'd4);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd180, 8'd190, 8'd160, 8'd0, 8'd220);
      queue_message(tps_pkg::CMD_TEMP, 8'd5, 8'd130, 8'd140, 8'd0, 8'd20, 8'd150);
      queue_message(tps_pkg::CMD_UNSUPPORTED, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_message(tps_pkg::CMD_CORNER_MAP, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd1);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_message(tps_pkg::CMD_TEMP, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_message(tps_pkg::CMD_PRESSURE, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_message(tps_pkg::CMD_TEMP, 8'd255, 8'd255, 8'd170, 8'd131, 8'd129, 8'd140);
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      program_thresholds(8191, 8191, -40, -40);
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      program_thresholds(0, 0, 215, 215);
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      program_thresholds(2000, 4000, 120, 60);
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      program_thresholds($urandom_range(0, 8191), $urandom_range(0, 8191),
                         int'($urandom_range(0, 255)) - 40, int'($urandom_range(0, 255)) - 40);
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      program_thresholds(int'(tps_pkg::PRESSURE_WARN_RESET),
                         int'(tps_pkg::PRESSURE_ALERT_RESET),
                         int'($signed(tps_pkg::TEMP_WARN_RESET)),
                         int'($signed(tps_pkg::TEMP_ALERT_RESET)));
      queue_random_messages(RANDOM_PER_PHASE);

      wait_idle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
src/tps_pkg.sv
src/tps_lane.sv
src/tps_merge.sv
src/tyre_pressure_slot_decoder.sv
src/tps_checker.sv
tb/tb_tyre_pressure_slot_decoder.sv
